FILE: rtl/core/pbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbr_pkg;

    localparam int LANE_W    = 8;
    localparam int OUT_LANES = 4;
    localparam int OUT_W     = LANE_W * OUT_LANES;
    localparam int CNT_W     = 3;
    localparam int RUN_W     = 8;

    // queue depth must stay a power of two, pointers wrap on their own
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [LANE_W-1:0] CODE_SKIP = 8'h80;

    // one unit of work for the back end: count copies of value, then an
    // optional truncation report
    typedef struct packed {
        logic [LANE_W-1:0] value;
        logic [RUN_W-1:0]  count;
        logic              trunc;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/pbr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       end_of_block;

    modport source (output valid, output code_byte, output end_of_block, input ready);
    modport sink   (input valid, input code_byte, input end_of_block, output ready);
endinterface

interface pbr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;
    logic        truncated;
    logic        last_of_item;

    modport source (
        output valid, output out_bytes, output byte_count, output truncated,
        output last_of_item, input ready
    );
    modport sink (
        input valid, input out_bytes, input byte_count, input truncated,
        input last_of_item, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/packbits_rle_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// path: first result of a byte is registered in the request queue, then in the result register
// throughput: literal bytes and headers go at one per cycle while the queue has room;
//   a repeat of n copies leaves as results of up to four bytes, and a truncation report
//   as one more; a two-entry request queue takes input meanwhile until it fills
// reset: synchronous active low, clears decode state, queue and output valid

module packbits_rle_decoder import pbr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pbr_in_if.sink     i_in,
    pbr_out_if.source  o_out
);

    logic push_ready, push, q_valid, q_pop;
    t_cmd push_cmd, q_cmd;

    pbr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .i_code_byte    (i_in.code_byte),
        .i_end_of_block (i_in.end_of_block),
        .o_ready        (i_in.ready),
        .i_push_ready   (push_ready),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    pbr_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_cmd        (q_cmd)
    );

    pbr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_out_bytes    (o_out.out_bytes),
        .o_byte_count   (o_out.byte_count),
        .o_truncated    (o_out.truncated),
        .o_last_of_item (o_out.last_of_item)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pbr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pbr_front import pbr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [LANE_W-1:0] i_code_byte,
    input  wire logic              i_end_of_block,
    output logic                   o_ready,
    input  wire logic              i_push_ready,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } t_mode_e;

    t_mode_e          r_mode, n_mode;
    logic [RUN_W-1:0] r_run, n_run;
    t_cmd             cmd;
    logic             accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    always_comb begin
        n_mode    = r_mode;
        n_run     = r_run;
        cmd       = '0;
        cmd.value = i_code_byte;
        case (r_mode)
            MODE_LITERAL: begin
                cmd.count = RUN_W'(1);
                n_run     = r_run - RUN_W'(1);
                if (n_run == '0) begin
                    n_mode = MODE_HEADER;
                end
            end
            MODE_REPEAT: begin
                cmd.count = r_run;
                n_mode    = MODE_HEADER;
                n_run     = '0;
            end
            default: begin
                if (!i_code_byte[LANE_W-1]) begin
                    n_mode = MODE_LITERAL;
                    n_run  = RUN_W'({1'b0, i_code_byte} + 9'd1);
                end else if (i_code_byte != CODE_SKIP) begin
                    // repeat count is one minus the signed header
                    n_mode = MODE_REPEAT;
                    n_run  = RUN_W'(9'd257 - {1'b0, i_code_byte});
                end else begin
                    n_mode = MODE_HEADER;
                    n_run  = '0;
                end
            end
        endcase
        if (i_end_of_block) begin
            cmd.trunc = (n_mode != MODE_HEADER);
            n_mode    = MODE_HEADER;
            n_run     = '0;
        end
    end

    assign o_push = accept && ((cmd.count != '0) || cmd.trunc);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;
            r_run  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_run  <= n_run;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pbr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pbr_cmd_fifo import pbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_push_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_push_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pbr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pbr_back import pbr_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire t_cmd          i_q_cmd,
    output logic               o_q_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [OUT_W-1:0]   o_out_bytes,
    output logic [CNT_W-1:0]   o_byte_count,
    output logic               o_truncated,
    output logic               o_last_of_item
);

    logic             r_active;
    t_cmd             r_cmd;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_bytes;
    logic [CNT_W-1:0] r_byte_count;
    logic             r_truncated;
    logic             r_last;

    t_cmd             cur, n_cmd;
    logic             load, data_res, res_last;
    logic [CNT_W-1:0] take;
    logic [RUN_W-1:0] left_after;
    logic [OUT_W-1:0] word;

    always_comb begin
        cur  = r_active ? r_cmd : i_q_cmd;
        load = (r_active || i_q_valid) && (!r_out_valid || i_ready);
        take = (cur.count < RUN_W'(OUT_LANES)) ? cur.count[CNT_W-1:0]
                                                : CNT_W'(OUT_LANES);
        left_after = cur.count - RUN_W'(take);
        for (int i = 0; i < OUT_LANES; i++) begin
            word[i*LANE_W +: LANE_W] = (CNT_W'(i) < take) ? cur.value : '0;
        end
        data_res = (cur.count != '0);
        // the truncation report, if any, always closes the item
        res_last    = data_res ? ((left_after == '0) && !cur.trunc) : 1'b1;
        n_cmd       = cur;
        n_cmd.count = data_res ? left_after : '0;
    end

    assign o_q_pop = load && !r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_active    <= !res_last;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd        <= n_cmd;
            r_out_bytes  <= data_res ? word : '0;
            r_byte_count <= data_res ? take : '0;
            r_truncated  <= !data_res;
            r_last       <= res_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_bytes    = r_out_bytes;
    assign o_byte_count   = r_byte_count;
    assign o_truncated    = r_truncated;
    assign o_last_of_item = r_last;

`ifndef NO_ASSERTIONS
    a_trunc_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_truncated) |-> (r_byte_count == '0 && r_last))
        else $error("truncation result carries bytes or is not last");

    a_data_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_truncated) |->
            (r_byte_count != '0 && r_byte_count <= CNT_W'(OUT_LANES)))
        else $error("data result has bad byte count");

    a_active_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cmd.count != '0 || r_cmd.trunc))
        else $error("back end holds a request with nothing left to do");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !res_last) |=> r_active)
        else $error("unfinished request dropped");
`endif

endmodule

`default_nettype wire
